>>> sv/fixed_partition_allocator_top_macros.svh
// Assertion macros shared by the checker of the fixed partition allocator.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef FIXED_PARTITION_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_PARTITION_ALLOCATOR_TOP_MACROS_SVH

// A condition that must hold at every sampled edge.
`define FPA_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define FPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An implication whose consequent is checked in the next cycle.
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/fpa_pkg.sv
// Package of the fixed partition allocator: field widths, codes and beat types.
// Used by the fragmentation unit, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

    localparam int MAX_PARTITIONS_DEF = 64;

    localparam int SIZE_W   = 13;
    localparam int COUNT_W  = 7;
    localparam int ID_W     = 16;
    localparam int PIDX_W   = 6;
    localparam int ADDR_W   = 18;
    localparam int FRAG_W   = 14;
    localparam int STAT_W   = 2;
    localparam int PROD_W   = SIZE_W + FRAG_W;
    localparam int ENTRY_W  = ID_W + SIZE_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [FRAG_W-1:0] FRAG_SCALE = FRAG_W'(10000);
    localparam logic [SIZE_W-1:0] PSIZE_RESET = SIZE_W'(4096);
    localparam logic [COUNT_W-1:0] PCOUNT_RESET = COUNT_W'(64);
    localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_ALLOC    = 2'd0,
        STAT_NOFIT    = 2'd1,
        STAT_FREED    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PART_SIZE  = 1'b0,
        CFG_PART_COUNT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        mode_t             mode;
        logic [SIZE_W-1:0] request_size;
        logic [ID_W-1:0]   free_id;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   process_id;
        logic [PIDX_W-1:0] partition_index;
        logic [ADDR_W-1:0] start_address;
        logic [SIZE_W-1:0] used_size;
        logic [FRAG_W-1:0] fragmentation;
    } rsp_t;

    // Command to the fragmentation unit.
    typedef struct packed {
        logic              start;
        logic [SIZE_W-1:0] part_size;
        logic [SIZE_W-1:0] req_size;
    } frag_cmd_t;

    // Answer of the fragmentation unit.
    typedef struct packed {
        logic              done;
        logic [FRAG_W-1:0] frag;
    } frag_rsp_t;

endpackage

`default_nettype wire

>>> sv/fpa_stream_if.sv
// Valid/ready channel used for the request and result beats of the allocator.
// The payload type is a parameter; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface fpa_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/fpa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module fpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/fpa_frag_unit.sv
// Fragmentation unit: (size - request) * 10000 / size by one multiply and a
// restoring divide of one quotient bit per cycle. Depends on fpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpa_frag_unit import fpa_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire frag_cmd_t cmd,
    output frag_rsp_t      rsp
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_DIV
    } fstate_t;

    localparam int CNT_W = $clog2(FRAG_W);

    fstate_t             state_reg;
    logic [SIZE_W-1:0]   diff_reg;
    logic [SIZE_W-1:0]   div_reg;
    logic [SIZE_W-1:0]   rem_reg;
    logic [FRAG_W-1:0]   quo_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                done_reg;

    logic [PROD_W-1:0]   prod;
    logic [SIZE_W:0]     trial;
    logic                qbit;

    // The quotient is below 2^FRAG_W, so the top bits of the product are
    // already below the divisor and serve as the first partial remainder.
    assign prod  = PROD_W'(diff_reg) * PROD_W'(FRAG_SCALE);
    assign trial = {rem_reg, quo_reg[FRAG_W-1]};
    assign qbit  = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            // The answer is flagged for one cycle after the last quotient bit.
            done_reg <= (state_reg == F_DIV) && (cnt_reg == CNT_W'(FRAG_W - 1));
            case (state_reg)
                F_IDLE:
                begin
                    if (cmd.start)
                    begin
                        diff_reg  <= cmd.part_size - cmd.req_size;
                        div_reg   <= cmd.part_size;
                        state_reg <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    rem_reg   <= prod[PROD_W-1:FRAG_W];
                    quo_reg   <= prod[FRAG_W-1:0];
                    cnt_reg   <= '0;
                    state_reg <= F_DIV;
                end
                F_DIV:
                begin
                    if (qbit)
                    begin
                        rem_reg <= SIZE_W'(trial - {1'b0, div_reg});
                    end
                    else
                    begin
                        rem_reg <= trial[SIZE_W-1:0];
                    end
                    quo_reg <= {quo_reg[FRAG_W-2:0], qbit};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(FRAG_W - 1))
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.frag = quo_reg;

endmodule

`default_nettype wire

>>> sv/fixed_partition_allocator_top.sv
// Top level of the fixed partition first-fit allocator.
// Depends on fpa_pkg, fpa_stream_if, fpa_ram and fpa_frag_unit.
//
// - req carries one request per beat: allocate with request_size, or free by free_id.
// - rsp returns exactly one result beat for every request beat, in order.
// - The configuration port writes partition_size (index 0) or partition_count
//   (index 1) on any edge with cfg_we high; the user must write only while nothing
//   is in flight; the block itself does not enforce this.
// - One request is handled at a time; req.ready is high only while the sequencer
//   is idle. An allocation walks the occupancy bits one partition per cycle up to
//   the first free index; the shared fragmentation unit then runs its multiply and
//   divide, S_EMIT loads the result, and the sequencer returns to idle for the next
//   request. A zero-sized request skips the unit, an oversized one goes straight to
//   S_EMIT, and a full table reports no fit once the scan passes the last partition.
// - A release reads the owner table one entry per cycle through the registered RAM
//   port until an occupied entry owned by free_id is found or the table ends.
// - The result sits in an output register. A new request is taken while it waits;
//   a following result is held by the sequencer until rsp.ready frees the register.
// - Reset clears the occupancy bits, sets the id counter to one and loads 64
//   partitions of 4096 KB. Owner entries count only while a partition is occupied.
`timescale 1ns / 1ps
`default_nettype none

module fixed_partition_allocator_top import fpa_pkg::*; #(
    parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [SIZE_W-1:0]    cfg_data,
    fpa_stream_if.sink                req,
    fpa_stream_if.source              rsp
);

    localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
    localparam int MUL_W = IDX_W + SIZE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_SCAN,
        S_FRAG,
        S_FREE_SCAN,
        S_EMIT
    } state_t;

    state_t                    state_reg;
    logic [SIZE_W-1:0]         psize_reg;
    logic [COUNT_W-1:0]        pcount_reg;
    logic [ID_W-1:0]           id_ctr_reg;
    logic [ID_W-1:0]           id_ctr_next;
    logic [MAX_PARTITIONS-1:0] occ_reg;
    logic [CNT_W-1:0]          scan_reg;
    logic                      pend_vld_reg;
    logic [IDX_W-1:0]          pend_idx_reg;
    logic [SIZE_W-1:0]         op_req_reg;
    logic [ID_W-1:0]           op_fid_reg;
    logic                      frag_start_reg;

    // Result being assembled, then the output register itself.
    status_t                   res_stat_reg;
    logic [ID_W-1:0]           res_id_reg;
    logic [IDX_W-1:0]          res_idx_reg;
    logic [SIZE_W-1:0]         res_used_reg;
    logic [FRAG_W-1:0]         res_frag_reg;
    logic                      rsp_vld_reg;
    rsp_t                      rsp_data_reg;

    logic [CNT_W-1:0]          act_cnt;
    logic [IDX_W-1:0]          scan_idx;
    logic                      scan_live;
    logic                      ram_we;
    logic [ENTRY_W-1:0]        ram_wdata;
    logic [ENTRY_W-1:0]        ram_rdata;
    logic [ID_W-1:0]           rd_owner;
    logic [SIZE_W-1:0]         rd_size;
    logic                      free_hit;
    logic                      emit_go;
    logic [MUL_W-1:0]          addr_full;
    frag_cmd_t                 frag_cmd;
    frag_rsp_t                 frag_rsp;

    // A partition count above the storage depth is used as the depth.
    assign act_cnt = (32'(pcount_reg) > 32'(MAX_PARTITIONS)) ?
                     CNT_W'(MAX_PARTITIONS) : CNT_W'(pcount_reg);

    assign scan_idx  = scan_reg[IDX_W-1:0];
    assign scan_live = (scan_reg < act_cnt);

    // The id counter skips zero when it wraps, so zero is never handed out.
    assign id_ctr_next = (id_ctr_reg == '1) ? ID_FIRST : id_ctr_reg + 1'b1;

    // The owner table is written in the cycle an allocation claims a slot.
    assign ram_we    = (state_reg == S_ALLOC_SCAN) && scan_live && !occ_reg[scan_idx];
    assign ram_wdata = {id_ctr_reg, op_req_reg};

    assign rd_owner = ram_rdata[ENTRY_W-1:SIZE_W];
    assign rd_size  = ram_rdata[SIZE_W-1:0];

    // The read data belongs to the entry whose read was issued in the previous cycle.
    assign free_hit = pend_vld_reg && occ_reg[pend_idx_reg] && (rd_owner == op_fid_reg);

    // The finished result moves into the output register once that is free.
    assign emit_go = (state_reg == S_EMIT) && (!rsp_vld_reg || rsp.ready);

    fpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PARTITIONS)
    ) u_owner_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (scan_idx),
        .wdata (ram_wdata),
        .raddr (scan_idx),
        .rdata (ram_rdata)
    );

    assign frag_cmd.start     = frag_start_reg;
    assign frag_cmd.part_size = psize_reg;
    assign frag_cmd.req_size  = op_req_reg;

    fpa_frag_unit u_frag (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (frag_cmd),
        .rsp   (frag_rsp)
    );

    // Start address uses the partition size in force when the beat leaves.
    assign addr_full = MUL_W'(res_idx_reg) * MUL_W'(psize_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            psize_reg      <= PSIZE_RESET;
            pcount_reg     <= PCOUNT_RESET;
            id_ctr_reg     <= ID_FIRST;
            occ_reg        <= '0;
            scan_reg       <= '0;
            pend_vld_reg   <= 1'b0;
            frag_start_reg <= 1'b0;
            rsp_vld_reg    <= 1'b0;
        end
        else
        begin
            // A claimed slot with a non-zero request starts the fragmentation unit.
            frag_start_reg <= ram_we && (op_req_reg != '0);

            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_idx))
                    CFG_PART_SIZE:  psize_reg  <= cfg_data;
                    CFG_PART_COUNT: pcount_reg <= cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (emit_go)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_vld_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_req_reg   <= req.data.request_size;
                        op_fid_reg   <= req.data.free_id;
                        scan_reg     <= '0;
                        pend_vld_reg <= 1'b0;
                        if (req.data.mode == MODE_FREE)
                        begin
                            state_reg <= S_FREE_SCAN;
                        end
                        else if ((psize_reg == '0) || (req.data.request_size > psize_reg))
                        begin
                            res_stat_reg <= STAT_NOFIT;
                            res_id_reg   <= '0;
                            res_idx_reg  <= '0;
                            res_used_reg <= '0;
                            res_frag_reg <= '0;
                            state_reg    <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_ALLOC_SCAN;
                        end
                    end
                end

                S_ALLOC_SCAN:
                begin
                    if (!scan_live)
                    begin
                        res_stat_reg <= STAT_NOFIT;
                        res_id_reg   <= '0;
                        res_idx_reg  <= '0;
                        res_used_reg <= '0;
                        res_frag_reg <= '0;
                        state_reg    <= S_EMIT;
                    end
                    else if (!occ_reg[scan_idx])
                    begin
                        occ_reg[scan_idx] <= 1'b1;
                        res_stat_reg      <= STAT_ALLOC;
                        res_id_reg        <= id_ctr_reg;
                        res_idx_reg       <= scan_idx;
                        res_used_reg      <= op_req_reg;
                        res_frag_reg      <= '0;
                        id_ctr_reg        <= id_ctr_next;
                        // A zero-sized request reports no fragmentation.
                        if (op_req_reg == '0)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_FRAG;
                        end
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end

                S_FRAG:
                begin
                    if (frag_rsp.done)
                    begin
                        res_frag_reg <= frag_rsp.frag;
                        state_reg    <= S_EMIT;
                    end
                end

                S_FREE_SCAN:
                begin
                    if (free_hit)
                    begin
                        occ_reg[pend_idx_reg] <= 1'b0;
                        res_stat_reg          <= STAT_FREED;
                        res_id_reg            <= op_fid_reg;
                        res_idx_reg           <= pend_idx_reg;
                        res_used_reg          <= rd_size;
                        res_frag_reg          <= '0;
                        state_reg             <= S_EMIT;
                    end
                    else if (scan_live)
                    begin
                        pend_idx_reg <= scan_idx;
                        pend_vld_reg <= 1'b1;
                        scan_reg     <= scan_reg + 1'b1;
                    end
                    else
                    begin
                        res_stat_reg <= STAT_NOTFOUND;
                        res_id_reg   <= '0;
                        res_idx_reg  <= '0;
                        res_used_reg <= '0;
                        res_frag_reg <= '0;
                        state_reg    <= S_EMIT;
                    end
                end

                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        rsp_data_reg.status          <= res_stat_reg;
                        rsp_data_reg.process_id      <= res_id_reg;
                        rsp_data_reg.partition_index <= PIDX_W'(res_idx_reg);
                        rsp_data_reg.start_address   <= ADDR_W'(addr_full);
                        rsp_data_reg.used_size       <= res_used_reg;
                        rsp_data_reg.fragmentation   <= res_frag_reg;
                        state_reg                    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_vld_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

`default_nettype wire

>>> sv/fpa_checker.sv
// Port-level checker for the fixed partition allocator and its bind statement.
// Depends on fpa_pkg and fixed_partition_allocator_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "fixed_partition_allocator_top_macros.svh"

module fpa_checker import fpa_pkg::*; (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp_data
);

    // A stalled result beat stays put.
    `FPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result beat changed while stalled")

    // Id zero is never handed out, so every success carries a real id.
    `FPA_ASSERT_IMP(a_id_nonzero, rsp_valid && (rsp_data.status == STAT_ALLOC || rsp_data.status == STAT_FREED), rsp_data.process_id != '0, "successful beat with id zero")

    // A failure reports nothing but its status.
    `FPA_ASSERT_IMP(a_fail_zero, rsp_valid && (rsp_data.status == STAT_NOFIT || rsp_data.status == STAT_NOTFOUND), rsp_data.process_id == '0 && rsp_data.partition_index == '0 && rsp_data.used_size == '0 && rsp_data.fragmentation == '0, "failure beat with non-zero fields")

    // Fragmentation is a share below one whole, and only allocations carry it.
    `FPA_ASSERT(a_frag_range, !rsp_valid || (rsp_data.fragmentation < FRAG_SCALE && (rsp_data.status == STAT_ALLOC || rsp_data.fragmentation == '0)), "fragmentation out of range")

endmodule

bind fixed_partition_allocator_top fpa_checker u_fpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire
